FILE: hw/rtl/url_percent_decoder_assert.svh
// Assertion helpers used by the top-level decoder module.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define URLDEC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("url decoder check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define URLDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("url decoder check failed");

`endif

FILE: hw/rtl/urldec_pkg.sv
`default_nettype none

package urldec_pkg;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Default number of entries in the front-to-back queue
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Most bytes one input can produce
    localparam int MAX_RESULTS = 3;

    // Escape tracking state
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    // One queue entry: the decoded bytes caused by one input
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [1:0]                  cnt;
        logic                        text_end;
    } t_entry;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

    function automatic logic urldec_is_hex(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) ||
               ((b >= 8'h41) && (b <= 8'h46)) ||
               ((b >= 8'h61) && (b <= 8'h66));
    endfunction

    function automatic logic [3:0] urldec_hex_value(input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        if ((b >= 8'h30) && (b <= 8'h39)) begin
            v = b - 8'h30;
        end else if ((b >= 8'h41) && (b <= 8'h46)) begin
            v = b - 8'h37;
        end else if ((b >= 8'h61) && (b <= 8'h66)) begin
            v = b - 8'h57;
        end
        return v[3:0];
    endfunction

    // Append one byte to an entry, dropping it once the entry is full
    function automatic t_entry urldec_append(input t_entry e, input logic [7:0] b);
        t_entry r;
        r = e;
        if (e.cnt != 2'(MAX_RESULTS)) begin
            r.data[e.cnt] = b;
            r.cnt         = e.cnt + 2'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/urldec_front.sv
`default_nettype none

module urldec_front
    import urldec_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [7:0]   i_byte,
    input  wire logic         i_last,
    input  wire t_fifo_status i_status,
    output logic              o_push,
    output t_entry            o_entry
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    t_entry     n_entry;
    logic       w_accept;

    assign o_ready  = !i_status.full;
    assign w_accept = i_valid && o_ready;

    // Classify the byte and build the list of decoded bytes
    always_comb begin
        logic is_h;
        logic do_plain;
        n_entry  = '0;
        n_phase  = r_phase;
        n_held   = r_held;
        is_h     = urldec_is_hex(i_byte);
        do_plain = 1'b0;
        unique case (r_phase)
            PH_PCT: begin
                if (is_h) begin
                    n_held  = i_byte;
                    n_phase = PH_DIGIT;
                end else begin
                    n_phase  = PH_IDLE;
                    n_entry  = urldec_append(n_entry, CH_PCT);
                    do_plain = 1'b1;
                end
            end
            PH_DIGIT: begin
                n_phase = PH_IDLE;
                if (is_h) begin
                    n_entry = urldec_append(n_entry,
                        {urldec_hex_value(r_held), urldec_hex_value(i_byte)});
                end else begin
                    n_entry  = urldec_append(n_entry, CH_PCT);
                    n_entry  = urldec_append(n_entry, r_held);
                    do_plain = 1'b1;
                end
            end
            default: begin
                n_phase  = PH_IDLE;
                do_plain = 1'b1;
            end
        endcase

        // Ordinary handling of the byte
        if (do_plain) begin
            if (i_byte == CH_PLUS) begin
                n_entry = urldec_append(n_entry, CH_SPACE);
            end else if (i_byte == CH_PCT) begin
                n_phase = PH_PCT;
            end else begin
                n_entry = urldec_append(n_entry, i_byte);
            end
        end

        // Flush an open escape at the end of the text
        if (i_last) begin
            if (n_phase == PH_PCT) begin
                n_entry = urldec_append(n_entry, CH_PCT);
            end else if (n_phase == PH_DIGIT) begin
                n_entry = urldec_append(n_entry, CH_PCT);
                n_entry = urldec_append(n_entry, n_held);
            end
            n_phase = PH_IDLE;
            n_held  = 8'h00;
        end
        n_entry.text_end = i_last;
    end

    // Advance escape state on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'h00;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    // Push only inputs that produce bytes
    assign o_push  = w_accept && (n_entry.cnt != 2'd0);
    assign o_entry = n_entry;

endmodule

`default_nettype wire

FILE: hw/rtl/urldec_fifo.sv
`default_nettype none

module urldec_fifo
    import urldec_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_head,
    output t_fifo_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire

FILE: hw/rtl/urldec_back.sv
`default_nettype none

module urldec_back
    import urldec_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_entry       i_head,
    input  wire t_fifo_status i_status,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [7:0]        o_byte,
    output logic              o_run_last,
    output logic              o_text_end
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_text_end;
    logic       w_load;
    logic       w_is_last;

    assign w_load    = !i_status.empty && (!r_valid || i_ready);
    assign w_is_last = (r_idx == (i_head.cnt - 2'd1));
    assign o_pop     = w_load && w_is_last;

    // Walk through the bytes of the head entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx   <= w_is_last ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte     <= i_head.data[r_idx];
            r_run_last <= w_is_last;
            r_text_end <= w_is_last && i_head.text_end;
        end
    end

    assign o_valid    = r_valid;
    assign o_byte     = r_byte;
    assign o_run_last = r_run_last;
    assign o_text_end = r_text_end;

endmodule

`default_nettype wire

FILE: hw/rtl/url_percent_decoder.sv
// Channel   | Dir | tdata (low bit up) | tlast         | tuser
// ----------+-----+--------------------+---------------+--------------
// s_axis    | in  | in_byte[7:0]       | in_last       | -
// m_axis    | out | out_byte[7:0]      | out_text_end  | out_run_last
//
// One input byte per cycle while the queue has room; a byte that gives
// several bytes is sent one byte per output transaction, as m_axis allows.
// A queue of QUEUE_DEPTH entries between classifier and emitter absorbs this.
// Decoded bytes go into the queue, then into the output register that drives valid.
// Reset is synchronous, active low, and returns the escape state to idle.
// Either side may stall; the input stalls only when the queue is full.
`default_nettype none

`include "url_percent_decoder_assert.svh"

module url_percent_decoder
    import urldec_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,
    output logic            m_axis_tuser    // [0] out_run_last
);

    t_fifo_status w_status;
    t_entry       w_push_entry;
    t_entry       w_head;
    logic         w_push;
    logic         w_pop;

    // Classify input bytes
    urldec_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_status (w_status),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    // Hold decoded groups between the two sides
    urldec_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_entry  (w_push_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    // Emit decoded bytes one per transaction
    urldec_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_status   (w_status),
        .o_pop      (w_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_run_last (m_axis_tuser),
        .o_text_end (m_axis_tlast)
    );

    // Text end only on the last byte of a group
    `URLDEC_ASSERT_NOW(a_end_is_run_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
    // Input stalls only on a full queue
    `URLDEC_ASSERT_NOW(a_stall_when_full, i_clk, i_rst_n, !s_axis_tready, w_status.full)
    // Never pop an empty queue
    `URLDEC_ASSERT_NOW(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_status.empty)
    // A push into an empty queue makes it non-empty
    `URLDEC_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push && w_status.empty, !w_status.empty)

endmodule

`default_nettype wire
